[rtl/aob_pkg.sv]
// Shared constants, register indexes and helper functions for the RGBA8 alpha-over blender.
// Used by rgba8_alpha_over_blend; no dependencies.
`timescale 1ns / 1ps

package aob_pkg;

    localparam int PIX_W                = 32;
    localparam int CFG_INDEX_W          = 3;
    localparam int CFG_DATA_W           = 9;
    localparam int WEIGHT_FRAC_BITS_DEF = 8;

    localparam logic [16:0] Q16_ONE      = 17'h10000;
    localparam logic [24:0] DIV255_RECIP = 25'h1010101;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SUBPIXEL_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OPACITY       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_LEFT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_RIGHT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_TOP    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_BOTTOM = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_LANE    = 3'd6;

    function automatic logic [7:0] byte_of(input logic [PIX_W-1:0] px, input logic [1:0] k);
        return px[8*k +: 8];
    endfunction

    // floor(x / 255) by reciprocal: the estimate is low by at most one, fix with one compare
    function automatic logic [16:0] div255(input logic [23:0] x);
        logic [48:0] prod;
        logic [16:0] q;
        logic [25:0] r;
        prod = 49'(x) * 49'(DIV255_RECIP);
        q    = prod[48:32];
        r    = 26'(x) - 26'({q, 8'd0}) + 26'(q);
        if (r >= 26'd255)
        begin
            q = q + 17'd1;
        end
        return q;
    endfunction

endpackage

[rtl/rgba8_alpha_over_blend.sv]
// Source-over compositing of an RGBA8 source onto an RGBA8 backdrop, direct or bilinear 2x2.
// Depends on aob_pkg and aob_div.
// Throughput: one beat per cycle while the skid slot is empty; the 16-stage colour
// dividers and the 17-stage mix-factor divider set the depth, each retiring one
// quotient bit per stage.
// A two-entry output register and skid slot decouple the output stall from the input.
// Reset loads register defaults and clears every stage valid bit; there is no clearing pass.
`timescale 1ns / 1ps

module rgba8_alpha_over_blend #(
    parameter int WEIGHT_FRAC_BITS = aob_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [aob_pkg::PIX_W-1:0]    src_pixel,
    input  logic [aob_pkg::PIX_W-1:0]    src_left,
    input  logic [aob_pkg::PIX_W-1:0]    src_above,
    input  logic [aob_pkg::PIX_W-1:0]    src_above_left,
    input  logic [aob_pkg::PIX_W-1:0]    backdrop_pixel,
    input  logic [3:0]                   neighbour_valid,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [aob_pkg::PIX_W-1:0]    result_pixel,
    input  logic                         cfg_write,
    input  logic [aob_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [aob_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import aob_pkg::*;

    localparam int WB    = (WEIGHT_FRAC_BITS + 1 < CFG_DATA_W) ? WEIGHT_FRAC_BITS + 1 : CFG_DATA_W;
    localparam int W2    = 2 * WB;
    localparam int AW_W  = 8 + W2;
    localparam int S_W   = AW_W + 2;
    localparam int P_W   = 8 + AW_W;
    localparam int N_W   = P_W + 2;
    localparam int NUM_W = N_W + 8;
    localparam int X_W   = S_W + 17;
    localparam int F2    = 2 * WEIGHT_FRAC_BITS;

    localparam logic [X_W-1:0] ASMP_HALF = X_W'(255) << (F2 - 1);
    localparam logic [X_W-1:0] Y_SAT     = X_W'(32'hFF0000);

    localparam int CS_QW      = 16;
    localparam int VAR_QW     = 17;
    localparam int ST_COL_IN  = 4;
    localparam int ST_VAR_IN  = 9;
    localparam int ST_COL_OUT = ST_COL_IN + CS_QW;
    localparam int ST_VAR_OUT = ST_VAR_IN + VAR_QW;
    localparam int CS_DLY     = ST_VAR_OUT - ST_COL_OUT;
    localparam int ST_LAST    = ST_VAR_OUT + 2;
    localparam int AB_IDX     = 6;

    function automatic logic [WB-1:0] clamp_w(input logic [CFG_DATA_W-1:0] w);
        if (32'(w) > (32'd1 << WEIGHT_FRAC_BITS))
        begin
            return WB'(32'd1 << WEIGHT_FRAC_BITS);
        end
        return WB'(w);
    endfunction

    // configuration
    logic              mode_reg;
    logic [7:0]        opacity_reg;
    logic [CFG_DATA_W-1:0] weight_reg [4];
    logic [1:0]        lane_reg;
    logic [W2-1:0]     wprod_reg [4];

    // skid
    logic              ov_reg;
    logic              sv_reg;
    logic [PIX_W-1:0]  od_reg;
    logic [PIX_W-1:0]  sd_reg;
    logic              adv;
    logic              load;

    // pipeline
    logic [ST_LAST-1:0] v_reg;
    logic [PIX_W-1:0]  bdp_reg [ST_VAR_OUT];
    logic [PIX_W-1:0]  s1_pix [4];
    logic [3:0]        s1_nv;
    logic [PIX_W-1:0]  s2_pix [4];
    logic [AW_W-1:0]   s2_aw [4];
    logic [AW_W-1:0]   s2_aw_next [4];
    logic [16:0]       s2_adir;
    logic [AW_W-1:0]   s3_aw [4];
    logic [P_W-1:0]    s3_prod [4][4];
    logic [PIX_W-1:0]  s3_sp;
    logic [16:0]       s3_adir;
    logic [S_W-1:0]    s4_s;
    logic [S_W-1:0]    s4_s_next;
    logic [N_W-1:0]    s4_n [4];
    logic [N_W-1:0]    s4_n_next [4];
    logic [16:0]       s4_adir;
    logic [X_W-1:0]    asmp_x;
    logic [X_W-1:0]    asmp_y;
    logic [16:0]       asmp_sub;
    logic [16:0]       s5_asmp;
    logic [23:0]       s6_t;
    logic [16:0]       s7_asrc;
    logic [23:0]       s8_u;
    logic [16:0]       s8_asrc;
    logic [16:0]       s9_ac;
    logic [16:0]       s9_asrc;
    logic              szero_reg [CS_QW];
    logic [16:0]       ac_reg [VAR_QW];
    logic [15:0]       q_col [4];
    logic [15:0]       cs_reg [CS_DLY][4];
    logic [16:0]       var_q;
    logic [16:0]       varc;
    logic [24:0]       s27_pa [4];
    logic [32:0]       s27_pb [4];
    logic [16:0]       s27_ac;
    logic [PIX_W-1:0]  res_next;
    logic [PIX_W-1:0]  s28_res;

    assign adv      = !sv_reg;
    assign in_stall = sv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            opacity_reg   <= 8'd255;
            weight_reg[0] <= 9'd256;
            weight_reg[1] <= 9'd0;
            weight_reg[2] <= 9'd256;
            weight_reg[3] <= 9'd0;
            lane_reg      <= 2'd3;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SUBPIXEL_MODE: mode_reg      <= cfg_data[0];
                REG_OPACITY:       opacity_reg   <= cfg_data[7:0];
                REG_WEIGHT_LEFT:   weight_reg[0] <= cfg_data;
                REG_WEIGHT_RIGHT:  weight_reg[1] <= cfg_data;
                REG_WEIGHT_TOP:    weight_reg[2] <= cfg_data;
                REG_WEIGHT_BOTTOM: weight_reg[3] <= cfg_data;
                REG_ALPHA_LANE:    lane_reg      <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    // window weights: upper left, upper right, lower left, lower right
    always_ff @(posedge clk)
    begin
        wprod_reg[0] <= W2'(clamp_w(weight_reg[0])) * W2'(clamp_w(weight_reg[2]));
        wprod_reg[1] <= W2'(clamp_w(weight_reg[1])) * W2'(clamp_w(weight_reg[2]));
        wprod_reg[2] <= W2'(clamp_w(weight_reg[0])) * W2'(clamp_w(weight_reg[3]));
        wprod_reg[3] <= W2'(clamp_w(weight_reg[1])) * W2'(clamp_w(weight_reg[3]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[ST_LAST-2:0], in_valid};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s2_aw_next[i] = s1_nv[i] ?
                AW_W'(byte_of(s1_pix[i], lane_reg)) * AW_W'(wprod_reg[i]) : '0;
        end
    end

    always_comb
    begin
        logic [S_W-1:0] sum_s;
        logic [N_W-1:0] sum_n;
        sum_s = '0;
        for (int i = 0; i < 4; i++)
        begin
            sum_s = sum_s + S_W'(s3_aw[i]);
        end
        // direct mode divides the plain byte by one
        s4_s_next = mode_reg ? sum_s : S_W'(1);
        for (int k = 0; k < 4; k++)
        begin
            sum_n = '0;
            for (int i = 0; i < 4; i++)
            begin
                sum_n = sum_n + N_W'(s3_prod[i][k]);
            end
            s4_n_next[k] = mode_reg ? sum_n : N_W'(byte_of(s3_sp, 2'(k)));
        end
    end

    assign asmp_x   = (X_W'(s4_s) << 16) + ASMP_HALF;
    assign asmp_y   = asmp_x >> F2;
    assign asmp_sub = (asmp_y >= Y_SAT) ? Q16_ONE : div255(asmp_y[23:0]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s2_pix[i] <= s1_pix[i];
                s2_aw[i]  <= s2_aw_next[i];
                s3_aw[i]  <= s2_aw[i];
                s4_n[i]   <= s4_n_next[i];
                for (int k = 0; k < 4; k++)
                begin
                    s3_prod[i][k] <= P_W'(byte_of(s2_pix[i], 2'(k))) * P_W'(s2_aw[i]);
                end
            end
            s1_pix[0]  <= src_above_left;
            s1_pix[1]  <= src_above;
            s1_pix[2]  <= src_left;
            s1_pix[3]  <= src_pixel;
            s1_nv      <= neighbour_valid;
            bdp_reg[0] <= backdrop_pixel;
            for (int j = 1; j < ST_VAR_OUT; j++)
            begin
                bdp_reg[j] <= bdp_reg[j-1];
            end
            s2_adir <= div255({byte_of(s1_pix[3], lane_reg), 16'd127});
            s3_adir <= s2_adir;
            s3_sp   <= s2_pix[3];
            s4_adir <= s3_adir;
            s4_s    <= s4_s_next;
            s5_asmp <= mode_reg ? asmp_sub : s4_adir;
            s6_t    <= 24'(25'(s5_asmp) * 25'(opacity_reg) + 25'd127);
            s7_asrc <= div255(s6_t);
            s8_u    <= 24'(25'(byte_of(bdp_reg[AB_IDX], lane_reg)) * 25'(Q16_ONE - s7_asrc));
            s8_asrc <= s7_asrc;
            s9_ac   <= s8_asrc + div255(s8_u);
            s9_asrc <= s8_asrc;
            szero_reg[0] <= (s4_s == '0);
            for (int j = 1; j < CS_QW; j++)
            begin
                szero_reg[j] <= szero_reg[j-1];
            end
            ac_reg[0] <= s9_ac;
            for (int j = 1; j < VAR_QW; j++)
            begin
                ac_reg[j] <= ac_reg[j-1];
            end
            for (int k = 0; k < 4; k++)
            begin
                cs_reg[0][k] <= szero_reg[CS_QW-1] ? '0 : q_col[k];
                for (int j = 1; j < CS_DLY; j++)
                begin
                    cs_reg[j][k] <= cs_reg[j-1][k];
                end
                s27_pa[k] <= 25'(Q16_ONE - varc) *
                             25'(byte_of(bdp_reg[ST_VAR_OUT-1], 2'(k)));
                s27_pb[k] <= 33'(varc) * 33'(cs_reg[CS_DLY-1][k]);
            end
            s27_ac  <= ac_reg[VAR_QW-1];
            s28_res <= res_next;
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_col_div
        aob_div #(
            .NUM_W (NUM_W),
            .DEN_W (S_W),
            .QUO_W (CS_QW)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .num ({s4_n[k], 8'd0}),
            .den (s4_s),
            .quo (q_col[k])
        );
    end

    aob_div #(
        .NUM_W (33),
        .DEN_W (17),
        .QUO_W (VAR_QW)
    ) u_var_div (
        .clk (clk),
        .en  (adv),
        .num ({s9_asrc, 16'd0} + 33'(s9_ac >> 1)),
        .den (s9_ac),
        .quo (var_q)
    );

    // zero composite alpha leaves the backdrop colour
    assign varc = (ac_reg[VAR_QW-1] == '0) ? '0 : ((var_q > Q16_ONE) ? Q16_ONE : var_q);

    always_comb
    begin
        logic [33:0] mix;
        logic [25:0] afull;
        logic [7:0]  abyte;
        logic [7:0]  cbyte;
        afull = (26'(s27_ac) << 8) - 26'(s27_ac);
        abyte = (afull[25:16] > 10'd255) ? 8'd255 : afull[23:16];
        for (int k = 0; k < 4; k++)
        begin
            mix   = 34'({s27_pa[k], 8'd0}) + 34'(s27_pb[k]) + 34'(1 << 23);
            cbyte = (mix[33:24] > 10'd255) ? 8'd255 : mix[31:24];
            res_next[8*k +: 8] = (2'(k) == lane_reg) ? abyte : cbyte;
        end
    end

    // output register with one skid slot
    assign load = v_reg[ST_LAST-1] && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (!ov_reg || !out_stall)
        begin
            ov_reg <= sv_reg || load;
            sv_reg <= 1'b0;
        end
        else if (load)
        begin
            sv_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ov_reg || !out_stall)
        begin
            od_reg <= sv_reg ? sd_reg : s28_res;
        end
        else if (load)
        begin
            sd_reg <= s28_res;
        end
    end

    assign out_valid    = ov_reg;
    assign result_pixel = od_reg;

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n) sv_reg |-> ov_reg)
        else $error("skid slot full while output register empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sv_reg) |-> $past(ov_reg && out_stall))
        else $error("skid slot filled without a stalled output beat");

    a_alpha_order: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_VAR_IN-1] |-> (s9_asrc <= s9_ac))
        else $error("source alpha exceeds composite alpha");

    a_var_range: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[ST_VAR_OUT-1] && (ac_reg[VAR_QW-1] != '0)) |-> (var_q <= Q16_ONE))
        else $error("mix factor above one");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[ST_COL_OUT-1] && !szero_reg[CS_QW-1]) |->
        ((q_col[0] <= 16'hFF00) && (q_col[1] <= 16'hFF00) &&
         (q_col[2] <= 16'hFF00) && (q_col[3] <= 16'hFF00)))
        else $error("sampled colour above full scale");

endmodule

[rtl/aob_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Used by rgba8_alpha_over_blend; no package dependencies.
`timescale 1ns / 1ps

module aob_div #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 28,
    parameter int QUO_W = 16
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] lo_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] lo_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (j == 0)
        begin : g_first
            // upper dividend bits stay below the divisor when the quotient fits
            assign rem_in = DEN_W'(num >> QUO_W);
            assign den_in = den;
            assign lo_in  = num[QUO_W-1:0];
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign lo_in  = lo_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign trial = {rem_in, lo_in[QUO_W-1-j]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                den_reg[j] <= den_in;
                lo_reg[j]  <= lo_in;
                quo_reg[j] <= {quo_in[QUO_W-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule
